[src/srecord_line_validator_core_macros.svh]
// assertion macros used by the port-level checker
`ifndef SRECORD_LINE_VALIDATOR_CORE_MACROS_SVH
`define SRECORD_LINE_VALIDATOR_CORE_MACROS_SVH

// same-cycle implication, off while reset is held
`define SRLV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define SRLV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also runs through reset
`define SRLV_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/srlv_pkg.sv]
// types, codes and helpers for the s-record line validator
package srlv_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_CHECKSUM    = 3'd1;
    localparam logic [2:0] ST_HEADER_LATE = 3'd2;
    localparam logic [2:0] ST_DATA_MISPL  = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE    = 3'd4;
    localparam logic [2:0] ST_NOT_S       = 3'd5;
    localparam logic [2:0] ST_HALTED      = 3'd6;

    localparam logic [3:0] KIND_HEADER = 4'd0;
    localparam logic [3:0] KIND_S1     = 4'd1;
    localparam logic [3:0] KIND_S2     = 4'd2;
    localparam logic [3:0] KIND_DATA   = 4'd3;
    localparam logic [3:0] KIND_S5     = 4'd5;
    localparam logic [3:0] KIND_END    = 4'd7;
    localparam logic [3:0] KIND_S8     = 4'd8;
    localparam logic [3:0] KIND_S9     = 4'd9;

    typedef struct packed {
        logic [7:0] text_char;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  line_status;
        logic [3:0]  record_kind;
        logic [15:0] line_number;
        logic [15:0] data_record_total;
        logic        end_misplaced;
    } t_out_item;

    // summary of one finished line, passed from front to back
    typedef struct packed {
        logic       starts_with_s;
        logic       sum_ok;
        logic [3:0] type_nibble;
    } t_line_info;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            d = c - CHAR_0;
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            d = c - CHAR_UP_A + 8'd10;
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
            d = c - CHAR_LO_A + 8'd10;
        end
        return d[3:0];
    endfunction

endpackage

[src/srlv_front.sv]
// character front end: hex pairing, count tracking and checksum sum per line
module srlv_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  srlv_pkg::t_in_item    i_item,
    input  logic                  i_q_full,
    output logic                  o_stall,
    output logic                  o_push,
    output srlv_pkg::t_line_info  o_info
);

    logic [7:0] r_idx, n_idx;
    logic [3:0] r_upper, n_upper;
    logic [3:0] r_type, n_type;
    logic [7:0] r_count, n_count;
    logic [7:0] r_taken, n_taken;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_last, n_last;
    logic       r_sws, n_sws;

    logic [3:0] hex;
    logic [7:0] byte_val;
    logic [7:0] k;
    logic       take;
    logic       line_done;

    assign o_stall = i_valid && i_item.line_end && i_q_full;
    assign o_push  = line_done;

    assign o_info.starts_with_s = r_sws;
    assign o_info.type_nibble   = r_type;
    assign o_info.sum_ok        = (r_idx >= 8'd4) && (r_count != 8'd0)
                                  && (r_taken == r_count) && (~r_sum == r_last);

    always_comb begin
        n_idx     = r_idx;
        n_upper   = r_upper;
        n_type    = r_type;
        n_count   = r_count;
        n_taken   = r_taken;
        n_sum     = r_sum;
        n_last    = r_last;
        n_sws     = r_sws;
        hex       = srlv_pkg::hex_value(i_item.text_char);
        byte_val  = {r_upper, hex};
        k         = r_taken + 8'd1;
        take      = i_valid && !i_item.line_end;
        line_done = i_valid && i_item.line_end && !i_q_full;

        if (take && r_idx != 8'hFF) begin
            if (r_idx == 8'd0) begin
                n_sws = (i_item.text_char == srlv_pkg::CHAR_S);
            end else if (r_idx == 8'd1) begin
                n_type = hex;
            end else if (!r_idx[0]) begin
                n_upper = hex;
            end else if (r_idx == 8'd3) begin
                n_count = byte_val;
                n_sum   = byte_val;
                n_taken = 8'd0;
            end else if (r_taken < r_count) begin
                // the count-th byte is the checksum, the rest go into the sum
                if (k < r_count) begin
                    n_sum = r_sum + byte_val;
                end else begin
                    n_last = byte_val;
                end
                n_taken = k;
            end
            n_idx = r_idx + 8'd1;
        end

        if (line_done) begin
            n_idx   = 8'd0;
            n_upper = 4'd0;
            n_type  = 4'd0;
            n_count = 8'd0;
            n_taken = 8'd0;
            n_sum   = 8'd0;
            n_last  = 8'd0;
            n_sws   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 8'd0;
            r_upper <= 4'd0;
            r_type  <= 4'd0;
            r_count <= 8'd0;
            r_taken <= 8'd0;
            r_sum   <= 8'd0;
            r_last  <= 8'd0;
            r_sws   <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_upper <= n_upper;
            r_type  <= n_type;
            r_count <= n_count;
            r_taken <= n_taken;
            r_sum   <= n_sum;
            r_last  <= n_last;
            r_sws   <= n_sws;
        end
    end

endmodule

[src/srlv_queue.sv]
// small fifo of finished-line summaries between front and back
module srlv_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  srlv_pkg::t_line_info  i_info,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_full,
    output srlv_pkg::t_line_info  o_info
);

    localparam int Depth = srlv_pkg::QUEUE_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    srlv_pkg::t_line_info r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_info  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + PtrW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CntW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_info;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[src/srlv_back.sv]
// back end: record order checks, counters, halt flag and result register
module srlv_back #(
    parameter int COUNTER_WIDTH = srlv_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  srlv_pkg::t_line_info  i_info,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output srlv_pkg::t_out_item   o_item
);

    logic                     r_header, n_header;
    logic                     r_data, n_data;
    logic                     r_end, n_end;
    logic                     r_halted, n_halted;
    logic [COUNTER_WIDTH-1:0] r_data_cnt, n_data_cnt;
    logic [COUNTER_WIDTH-1:0] r_line_cnt, n_line_cnt;
    logic                     r_valid;
    srlv_pkg::t_out_item      r_item, n_item;

    logic [2:0]               type_fail;
    logic [2:0]               status;
    logic                     misplaced;
    logic [COUNTER_WIDTH+15:0] line_ext;
    logic [COUNTER_WIDTH+15:0] data_ext;

    assign o_pop   = i_q_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_header   = r_header;
        n_data     = r_data;
        n_end      = r_end;
        n_halted   = r_halted;
        n_data_cnt = r_data_cnt;
        n_line_cnt = (r_line_cnt != '1) ? r_line_cnt + COUNTER_WIDTH'(1) : r_line_cnt;
        type_fail  = srlv_pkg::ST_OK;
        status     = srlv_pkg::ST_OK;
        misplaced  = 1'b0;

        if (r_halted) begin
            status = srlv_pkg::ST_HALTED;
        end else if (!i_info.starts_with_s) begin
            status = srlv_pkg::ST_NOT_S;
        end else begin
            unique case (i_info.type_nibble) inside
                srlv_pkg::KIND_HEADER: begin
                    if (r_data || r_end) type_fail = srlv_pkg::ST_HEADER_LATE;
                    n_header = 1'b1;
                end
                srlv_pkg::KIND_DATA: begin
                    if (!r_header || r_end) type_fail = srlv_pkg::ST_DATA_MISPL;
                    n_data = 1'b1;
                    if (r_data_cnt != '1) n_data_cnt = r_data_cnt + COUNTER_WIDTH'(1);
                end
                srlv_pkg::KIND_END: begin
                    misplaced = !r_header || r_end;
                    n_end     = 1'b1;
                end
                srlv_pkg::KIND_S1, srlv_pkg::KIND_S2, srlv_pkg::KIND_S5,
                srlv_pkg::KIND_S8, srlv_pkg::KIND_S9: begin
                end
                default: begin
                    type_fail = srlv_pkg::ST_BAD_TYPE;
                end
            endcase
            status = i_info.sum_ok ? type_fail : srlv_pkg::ST_CHECKSUM;
        end
        if (status != srlv_pkg::ST_OK) n_halted = 1'b1;

        // saturate the counters to the 16-bit result fields
        line_ext = {16'd0, n_line_cnt};
        data_ext = {16'd0, n_data_cnt};

        n_item.line_status       = status;
        n_item.record_kind       = i_info.type_nibble;
        n_item.line_number       = (|line_ext[COUNTER_WIDTH+15:16]) ? 16'hFFFF
                                                                     : line_ext[15:0];
        n_item.data_record_total = (|data_ext[COUNTER_WIDTH+15:16]) ? 16'hFFFF
                                                                     : data_ext[15:0];
        n_item.end_misplaced     = misplaced;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header   <= 1'b0;
            r_data     <= 1'b0;
            r_end      <= 1'b0;
            r_halted   <= 1'b0;
            r_data_cnt <= '0;
            r_line_cnt <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_header   <= n_header;
                r_data     <= n_data;
                r_end      <= n_end;
                r_halted   <= n_halted;
                r_data_cnt <= n_data_cnt;
                r_line_cnt <= n_line_cnt;
                r_valid    <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

[src/srecord_line_validator_core.sv]
// S-record line validator, top level
// Input channel: one text character per transaction (i_in.text_char); a
// transaction with i_in.line_end set closes the current line and its
// character is ignored. Output channel: one status transaction per line,
// carrying status, record type, line number, S3 total and the S7 order flag.
// Characters are taken one per cycle with no stall. A line end is stalled
// only while the two-entry line queue between the character front end and
// the record back end is full, which happens only when the receiver stalls.
// The summary of a line is written into the line queue at the edge accepting
// its line-end transaction; the back end then pops it into the output register.
// While the receiver does not stall, the back end retires one line per cycle, so
// lines as short as a single line-end transaction also stream at one per cycle.
// A stalled result holds in the output register while the front end keeps
// taking characters and up to two finished lines wait in the queue.
// Reset (synchronous, active low) clears line state, order flags, the halt
// flag and both counters, and empties queue and output register. After the
// first failing line every later line reports halted.
module srecord_line_validator_core #(
    parameter int COUNTER_WIDTH = srlv_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  srlv_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output srlv_pkg::t_out_item  o_out
);

    logic                 push;
    logic                 pop;
    logic                 q_valid;
    logic                 q_full;
    srlv_pkg::t_line_info front_info;
    srlv_pkg::t_line_info q_info;

    srlv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_item   (i_in),
        .i_q_full (q_full),
        .o_stall  (o_in_stall),
        .o_push   (push),
        .o_info   (front_info)
    );

    srlv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_info  (front_info),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_info  (q_info)
    );

    srlv_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_info    (q_info),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out)
    );

endmodule

[src/srlv_checker.sv]
// port-level checks for the s-record line validator, bound to the top level
`include "srecord_line_validator_core_macros.svh"

module srlv_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input srlv_pkg::t_in_item   i_in,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input srlv_pkg::t_out_item  o_out
);

    `SRLV_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out), "stalled result changed")
    `SRLV_ASSERT_ALWAYS_NEXT(a_reset_empty, !i_rst_n, !o_out_valid, "result valid after reset")
    `SRLV_ASSERT_NOW(a_misplaced_kind, o_out_valid && o_out.end_misplaced,
        o_out.record_kind == srlv_pkg::KIND_END && (o_out.line_status == srlv_pkg::ST_OK
        || o_out.line_status == srlv_pkg::ST_CHECKSUM), "order flag on wrong line")
    `SRLV_ASSERT_NOW(a_line_number, o_out_valid, o_out.line_number != 16'd0, "line number zero")
    `SRLV_ASSERT_NOW(a_stall_eol, i_in_valid && o_in_stall, i_in.line_end,
        "character transaction stalled")

endmodule

bind srecord_line_validator_core srlv_checker u_srlv_checker (.*);

[tb/testbench.sv]
// testbench for the s-record line validator: record streams checked against a line predictor
`timescale 1ns / 100ps

module testbench;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF_CYCLES = 100;
    localparam int HOLD_OFF_AT = 12;

    // record types the block rejects
    localparam logic [3:0] KIND_S4 = 4'd4;
    localparam logic [3:0] KIND_S6 = 4'd6;

    typedef enum {FLAW_NONE, FLAW_SUM, FLAW_SHORT} t_rec_flaw;
    typedef enum {
        BREAK_SUM, BREAK_SHORT, BREAK_ZERO_COUNT, BREAK_NOT_S,
        BREAK_EMPTY, BREAK_LATE_HEADER, BREAK_LATE_DATA, BREAK_BAD_TYPE
    } t_line_break;

    typedef struct {
        srlv_pkg::t_in_item item;
        bit                 drain_first;
    } t_feed_entry;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    srlv_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    srlv_pkg::t_out_item out_item;

    t_feed_entry         char_feed[$];
    srlv_pkg::t_out_item line_reports_due[$];

    bit drain_next = 1'b0;
    int chars_queued = 0;
    int lines_queued = 0;
    int items_sent = 0;
    int reports_taken = 0;
    int mismatches = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int status_tally[8];
    int misplaced_tally = 0;

    // predictor state, cleared like the block at reset
    logic [7:0]  line_pos = '0;
    logic [3:0]  hi_nibble = '0;
    logic [3:0]  rec_type = '0;
    logic [7:0]  rec_count = '0;
    logic [7:0]  rec_taken = '0;
    logic [7:0]  rec_sum = '0;
    logic [7:0]  rec_last = '0;
    bit          line_is_s = 1'b0;
    bit          have_header = 1'b0;
    bit          have_data = 1'b0;
    bit          have_end = 1'b0;
    bit          frozen = 1'b0;
    logic [15:0] s3_count = '0;
    logic [15:0] line_count = '0;

    srecord_line_validator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= srlv_pkg::CHAR_0 && c <= srlv_pkg::CHAR_9) begin
            v = c[3:0];
        end else if ((c >= srlv_pkg::CHAR_UP_A && c <= srlv_pkg::CHAR_UP_F) ||
                     (c >= srlv_pkg::CHAR_LO_A && c <= srlv_pkg::CHAR_LO_F)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    // returns 1 with the report when the character closes a line
    function automatic bit predict_line_report(input srlv_pkg::t_in_item it,
                                               output srlv_pkg::t_out_item rep);
        logic [7:0] b;
        logic [7:0] k;
        logic [2:0] order_status;
        bit         sum_good;
        rep = '0;
        if (!it.line_end) begin
            if (line_pos != 8'hFF) begin
                if (line_pos == 8'd0) begin
                    line_is_s = (it.text_char == srlv_pkg::CHAR_S);
                end else if (line_pos == 8'd1) begin
                    rec_type = nibble_of(it.text_char);
                end else if (!line_pos[0]) begin
                    hi_nibble = nibble_of(it.text_char);
                end else begin
                    b = {hi_nibble, nibble_of(it.text_char)};
                    if (line_pos == 8'd3) begin
                        rec_count = b;
                        rec_sum = b;
                        rec_taken = 8'd0;
                    end else if (rec_taken < rec_count) begin
                        k = rec_taken + 8'd1;
                        if (k < rec_count) begin
                            rec_sum = rec_sum + b;
                        end else begin
                            rec_last = b;
                        end
                        rec_taken = k;
                    end
                end
                line_pos = line_pos + 8'd1;
            end
            return 1'b0;
        end

        if (line_count != 16'hFFFF) line_count = line_count + 16'd1;
        if (frozen) begin
            rep.line_status = srlv_pkg::ST_HALTED;
        end else if (!line_is_s) begin
            rep.line_status = srlv_pkg::ST_NOT_S;
        end else begin
            sum_good = line_pos >= 8'd4 && rec_count != 8'd0 && rec_taken == rec_count &&
                       (~rec_sum) == rec_last;
            order_status = srlv_pkg::ST_OK;
            case (rec_type)
                srlv_pkg::KIND_HEADER: begin
                    if (have_data || have_end) order_status = srlv_pkg::ST_HEADER_LATE;
                    have_header = 1'b1;
                end
                srlv_pkg::KIND_DATA: begin
                    if (!have_header || have_end) order_status = srlv_pkg::ST_DATA_MISPL;
                    have_data = 1'b1;
                    if (s3_count != 16'hFFFF) s3_count = s3_count + 16'd1;
                end
                srlv_pkg::KIND_END: begin
                    rep.end_misplaced = !have_header || have_end;
                    have_end = 1'b1;
                end
                srlv_pkg::KIND_S1, srlv_pkg::KIND_S2, srlv_pkg::KIND_S5,
                srlv_pkg::KIND_S8, srlv_pkg::KIND_S9: begin
                end
                default: begin
                    order_status = srlv_pkg::ST_BAD_TYPE;
                end
            endcase
            rep.line_status = sum_good ? order_status : srlv_pkg::ST_CHECKSUM;
        end
        if (rep.line_status != srlv_pkg::ST_OK) frozen = 1'b1;
        rep.record_kind = rec_type;
        rep.line_number = line_count;
        rep.data_record_total = s3_count;

        line_pos = '0;
        hi_nibble = '0;
        rec_type = '0;
        rec_count = '0;
        rec_taken = '0;
        rec_sum = '0;
        rec_last = '0;
        line_is_s = 1'b0;
        return 1'b1;
    endfunction

    // a hex digit in a random spelling; zero sometimes as a character that is not hex at all
    function automatic logic [7:0] digit_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) begin
            c = srlv_pkg::CHAR_0 + {4'd0, v};
        end else begin
            c = ($urandom_range(1) ? srlv_pkg::CHAR_UP_A : srlv_pkg::CHAR_LO_A) +
                {4'd0, v - 4'd10};
        end
        if (v == 4'd0 && $urandom_range(7) == 0) begin
            do begin
                c = 8'($urandom);
            end while (nibble_of(c) != 4'd0);
        end
        return c;
    endfunction

    function automatic logic [3:0] pick_plain_kind();
        logic [3:0] kind;
        case ($urandom_range(4))
            0: kind = srlv_pkg::KIND_S1;
            1: kind = srlv_pkg::KIND_S2;
            2: kind = srlv_pkg::KIND_S5;
            3: kind = srlv_pkg::KIND_S8;
            default: kind = srlv_pkg::KIND_S9;
        endcase
        return kind;
    endfunction

    task automatic push_char(input logic [7:0] c, input logic eol);
        t_feed_entry e;
        e.item.text_char = c;
        e.item.line_end = eol;
        e.drain_first = drain_next;
        drain_next = 1'b0;
        char_feed.push_back(e);
        if (eol) lines_queued++;
        else chars_queued++;
    endtask

    task automatic queue_record(input logic [3:0] kind, input int count, input t_rec_flaw flaw,
                                input int extra);
        logic [7:0] payload[$];
        logic [7:0] txt[$];
        logic [7:0] total;
        logic [7:0] b;
        int         keep;
        total = count[7:0];
        payload.push_back(count[7:0]);
        for (int i = 1; i < count; i++) begin
            b = 8'($urandom);
            payload.push_back(b);
            total = total + b;
        end
        if (count > 0) begin
            b = ~total;
            if (flaw == FLAW_SUM) b = b ^ (8'd1 << $urandom_range(7));
            payload.push_back(b);
        end
        repeat (extra) payload.push_back(8'($urandom));
        txt.push_back(srlv_pkg::CHAR_S);
        txt.push_back(digit_char(kind));
        foreach (payload[i]) begin
            txt.push_back(digit_char(payload[i][7:4]));
            txt.push_back(digit_char(payload[i][3:0]));
        end
        if (flaw == FLAW_SHORT) begin
            keep = $urandom_range(txt.size() - 1, 2);
            while (txt.size() > keep) void'(txt.pop_back());
        end
        foreach (txt[i]) push_char(txt[i], 1'b0);
        push_char(8'($urandom), 1'b1);
    endtask

    task automatic queue_noise_line(input int len, input bit not_s);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            c = 8'($urandom);
            if (i == 0 && not_s && c == srlv_pkg::CHAR_S) c = c ^ 8'h20;
            push_char(c, 1'b0);
        end
        push_char(8'($urandom), 1'b1);
    endtask

    // sender: one character per transaction, predictions made on acceptance
    always @(posedge clk) begin : drive_chars
        srlv_pkg::t_out_item rep;
        bit                  take_next;
        bit                  gap;
        bit                  calm;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_item <= '0;
        end else begin
            if (in_valid && !in_stall) begin
                if (predict_line_report(in_item, rep)) line_reports_due.push_back(rep);
            end
            take_next = !in_valid || !in_stall;
            if (take_next) begin
                calm = items_sent >= 300 && items_sent < 460;
                gap = !calm && ($urandom_range(99) < 16);
                if (char_feed.size() > 0 && !gap &&
                    !(char_feed[0].drain_first && line_reports_due.size() != 0)) begin
                    in_item <= char_feed[0].item;
                    in_valid <= 1'b1;
                    void'(char_feed.pop_front());
                    items_sent++;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: compare each line report with the oldest prediction
    always @(posedge clk) begin : check_reports
        srlv_pkg::t_out_item want;
        bit                  calm;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                reports_taken++;
                if (line_reports_due.size() == 0) begin
                    $error("unexpected line report: line_status %0d, line_number %0d",
                           out_item.line_status, out_item.line_number);
                    mismatches++;
                end else begin
                    want = line_reports_due.pop_front();
                    status_tally[want.line_status]++;
                    if (want.end_misplaced) misplaced_tally++;
                    if (out_item.line_status !== want.line_status) begin
                        $error("line_status: expected %0d, got %0d",
                               want.line_status, out_item.line_status);
                        mismatches++;
                    end
                    if (out_item.record_kind !== want.record_kind) begin
                        $error("record_kind: expected %0d, got %0d",
                               want.record_kind, out_item.record_kind);
                        mismatches++;
                    end
                    if (out_item.line_number !== want.line_number) begin
                        $error("line_number: expected %0d, got %0d",
                               want.line_number, out_item.line_number);
                        mismatches++;
                    end
                    if (out_item.data_record_total !== want.data_record_total) begin
                        $error("data_record_total: expected %0d, got %0d",
                               want.data_record_total, out_item.data_record_total);
                        mismatches++;
                    end
                    if (out_item.end_misplaced !== want.end_misplaced) begin
                        $error("end_misplaced: expected %0d, got %0d",
                               want.end_misplaced, out_item.end_misplaced);
                        mismatches++;
                    end
                end
                // long hold-off so the line queue fills and the input stalls
                if (reports_taken == HOLD_OFF_AT) hold_left = HOLD_OFF_CYCLES;
            end
            calm = reports_taken >= 20 && reports_taken < 34;
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 16);
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [7:0]  opener[12];
        t_line_break brk;
        int          pick;
        opener = '{srlv_pkg::CHAR_S, srlv_pkg::CHAR_0, "0", "4", 8'h00, 8'hFF,
                   "a", "F", "0", "9", "4", "3"};

        // header with mixed-case digits and zero nibbles spelled as 0x00 and 0xff
        foreach (opener[i]) push_char(opener[i], 1'b0);
        push_char(8'hFF, 1'b1);
        queue_record(srlv_pkg::KIND_DATA, 1, FLAW_NONE, 0);
        queue_record(srlv_pkg::KIND_S9, 2, FLAW_NONE, 1);

        // well-formed data section with random content
        drain_next = 1'b1;
        while (lines_queued < 40) begin
            pick = $urandom_range(99);
            if (lines_queued == 14) begin
                // largest count that fits, then characters past the saturated index
                queue_record(srlv_pkg::KIND_DATA, 125, FLAW_NONE, 3);
            end else if (pick < 12) begin
                queue_record(pick_plain_kind(), $urandom_range(8, 1), FLAW_NONE, 0);
            end else if (pick < 22) begin
                queue_record(srlv_pkg::KIND_DATA, $urandom_range(8, 1), FLAW_NONE,
                             $urandom_range(3, 1));
            end else begin
                queue_record(srlv_pkg::KIND_DATA, $urandom_range(8, 1), FLAW_NONE, 0);
            end
        end

        // end records, the second one out of order
        drain_next = 1'b1;
        queue_record(srlv_pkg::KIND_END, $urandom_range(5, 1), FLAW_NONE, 0);
        queue_record(srlv_pkg::KIND_END, $urandom_range(5, 1), FLAW_NONE, 0);
        repeat (3) queue_record(pick_plain_kind(), $urandom_range(6, 1), FLAW_NONE, 0);

        // one failing line, then everything after it reports halted
        brk = t_line_break'($urandom_range(7));
        case (brk)
            BREAK_SUM: begin
                queue_record(srlv_pkg::KIND_DATA, $urandom_range(8, 1), FLAW_SUM, 0);
            end
            BREAK_SHORT: begin
                queue_record(srlv_pkg::KIND_S1, $urandom_range(8, 1), FLAW_SHORT, 0);
            end
            BREAK_ZERO_COUNT: begin
                queue_record(srlv_pkg::KIND_S5, 0, FLAW_NONE, $urandom_range(3, 0));
            end
            BREAK_NOT_S:       queue_noise_line($urandom_range(12, 1), 1'b1);
            BREAK_EMPTY:       push_char(8'($urandom), 1'b1);
            BREAK_LATE_HEADER: begin
                queue_record(srlv_pkg::KIND_HEADER, $urandom_range(6, 1), FLAW_NONE, 0);
            end
            BREAK_LATE_DATA: begin
                queue_record(srlv_pkg::KIND_DATA, $urandom_range(6, 1), FLAW_NONE, 0);
            end
            default: begin
                pick = $urandom_range(7);
                queue_record(pick == 0 ? KIND_S4 :
                             pick == 1 ? KIND_S6 : 4'($urandom_range(15, 10)),
                             $urandom_range(6, 1), FLAW_NONE, 0);
            end
        endcase
        while (chars_queued + lines_queued < 650 || lines_queued < 56) begin
            if ($urandom_range(1)) queue_noise_line($urandom_range(16, 0), 1'b0);
            else queue_record(4'($urandom), $urandom_range(6, 1), FLAW_NONE, 0);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (char_feed.size() != 0 || in_valid || line_reports_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d characters in %0d lines, failing line case %s",
                 chars_queued, lines_queued, brk.name());
        $display("reports: ok %0d, checksum %0d, header late %0d, data misplaced %0d,",
                 status_tally[srlv_pkg::ST_OK], status_tally[srlv_pkg::ST_CHECKSUM],
                 status_tally[srlv_pkg::ST_HEADER_LATE], status_tally[srlv_pkg::ST_DATA_MISPL],
                 " bad type %0d, not S %0d, halted %0d, end misplaced %0d",
                 status_tally[srlv_pkg::ST_BAD_TYPE], status_tally[srlv_pkg::ST_NOT_S],
                 status_tally[srlv_pkg::ST_HALTED], misplaced_tally);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

[srecord_line_validator_core.f]
+incdir+src
src/srlv_pkg.sv
src/srlv_front.sv
src/srlv_queue.sv
src/srlv_back.sv
src/srecord_line_validator_core.sv
src/srlv_checker.sv
tb/testbench.sv
